/* sv/rlts_pkg.sv */
// rlts_pkg: types and constants shared by the reservation/limit tag scheduler
// holds the request, response and queue entry structs plus status codes
// no dependencies
`default_nettype none
package rlts_pkg;

   localparam int TENANTS_DEF     = 16;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int FRAC_BITS_DEF   = 8;

   localparam logic [23:0] CLOCK_MOD = 24'd10000000;
   localparam logic [15:0] STEP_RESET = 16'd256;

   // configuration register indexes
   localparam logic REG_RES_STEP = 1'b0;
   localparam logic REG_LIM_STEP = 1'b1;

   // response status codes
   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_RES  = 2'd1;
   localparam logic [1:0] ST_WGT  = 2'd2;
   localparam logic [1:0] ST_DROP = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [3:0]  tenant;
      logic [15:0] request_id;
      logic [15:0] rho;
      logic [15:0] delta;
      logic [23:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_id;
      logic [3:0]  granted_tenant;
   } rsp_type;

   typedef struct packed {
      logic [31:0] r_tag;
      logic [31:0] l_tag;
      logic [31:0] p_tag;
      logic [15:0] id;
      logic [3:0]  tenant;
   } entry_type;

endpackage
`default_nettype wire

/* sv/reservation_limit_tag_scheduler_unit.sv */
// reservation_limit_tag_scheduler_unit: dmclock style tag scheduler, one module
// sequencer around a shared multiplier, saturating adder and a queue memory
// depends on rlts_pkg
//
// One transaction at a time: start is taken when busy is low, and the single
// response appears on rsp_data for exactly one cycle with rsp_strobe high; the
// receiver cannot stall it. A tag arrival steps through the reservation and
// limit multiply and update states, then a min search over the tenant share tags
// when the tenant's share tag is zero and a subtract pass when some other share
// tag is nonzero, then the share tag update and queue write; a dropped arrival on
// a full queue goes straight to the response. A grant scans the queued entries
// through the registered queue memory read port, then compacts the queue after
// removal, reading and writing back one entry at a time.
`default_nettype none
module reservation_limit_tag_scheduler_unit #(
   parameter int TENANTS     = rlts_pkg::TENANTS_DEF,
   parameter int QUEUE_DEPTH = rlts_pkg::QUEUE_DEPTH_DEF,
   parameter int FRAC_BITS   = rlts_pkg::FRAC_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire rlts_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output rlts_pkg::rsp_type      rsp_data,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [15:0]             csr_wdata
);

   localparam int TW = (TENANTS > 1) ? $clog2(TENANTS) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_MUL_R  = 13'b0000000000010,
      S_UPD_R  = 13'b0000000000100,
      S_MUL_L  = 13'b0000000001000,
      S_UPD_L  = 13'b0000000010000,
      S_SH_MIN = 13'b0000000100000,
      S_SH_SUB = 13'b0000001000000,
      S_UPD_P  = 13'b0000010000000,
      S_SC_RD  = 13'b0000100000000,
      S_SC_EV  = 13'b0001000000000,
      S_CP_RD  = 13'b0010000000000,
      S_CP_WR  = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] rstep_ff, lstep_ff;
   logic [31:0] res_ff [TENANTS];
   logic [31:0] lim_ff [TENANTS];
   logic [31:0] sh_ff  [TENANTS];
   logic [31:0] res_in [TENANTS];
   logic [31:0] lim_in [TENANTS];
   logic [31:0] sh_in  [TENANTS];

   rlts_pkg::req_type req_ff, req_in;
   logic [TW-1:0] ten_ff, ten_in;
   logic [31:0]   now_ff, now_in;
   logic [31:0]   prod_ff, prod_in;
   logic [QW:0]   count_ff, count_in;
   logic [QW:0]   qi_ff, qi_in;
   logic [TW:0]   ti_ff, ti_in;
   logic          found_ff, found_in;
   logic [31:0]   mn_ff, mn_in;

   // scan tracking
   logic          hr_ff, hr_in, hp_ff, hp_in;
   logic [31:0]   rmin_ff, rmin_in, pmin_ff, pmin_in;
   logic [QW-1:0] ri_ff, ri_in, pi_ff, pi_in;
   logic [15:0]   rid_ff, rid_in, pid_ff, pid_in;
   logic [3:0]    rten_ff, rten_in, pten_ff, pten_in;
   logic [QW-1:0] sel_ff, sel_in;
   logic [3:0]    selten_ff, selten_in;
   logic          wgt_ff, wgt_in;

   rlts_pkg::rsp_type res_ff_r, res_in_r;

   // queue memory
   rlts_pkg::entry_type mem [QUEUE_DEPTH];
   rlts_pkg::entry_type rd_ff;
   logic [QW-1:0]       raddr, waddr;
   logic                mem_we;
   rlts_pkg::entry_type wdata;

   // shared arithmetic
   logic [15:0] mul_a, mul_b;
   logic [31:0] add_a, add_b, add_sat, add_res;
   logic [32:0] add_sum;
   logic [TW-1:0] tidx;
   logic [31:0]   sh_rd;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);
   assign rsp_data   = res_ff_r;

   assign tidx  = (state_ff == S_SH_MIN || state_ff == S_SH_SUB) ? ti_ff[TW-1:0] : ten_ff;
   assign sh_rd = sh_ff[tidx];

   assign mul_a   = (state_ff == S_MUL_R) ? req_ff.rho : req_ff.delta;
   assign mul_b   = (state_ff == S_MUL_R) ? rstep_ff : lstep_ff;
   assign prod_in = 32'(mul_a) * 32'(mul_b);

   assign add_sum = {1'b0, add_a} + {1'b0, add_b};
   assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
   assign add_res = (add_sat > now_ff) ? add_sat : now_ff;

   always_comb begin
      logic [3:0]  tv;
      logic [23:0] nm;
      logic [39:0] ext;
      logic        r_take, p_take;
      logic [QW:0] start_i;
      logic [QW:0] src;
      logic [31:0] rv;
      rlts_pkg::entry_type e;

      state_in  = state_ff;
      res_in    = res_ff;
      lim_in    = lim_ff;
      sh_in     = sh_ff;
      req_in    = req_ff;
      ten_in    = ten_ff;
      now_in    = now_ff;
      count_in  = count_ff;
      qi_in     = qi_ff;
      ti_in     = ti_ff;
      found_in  = found_ff;
      mn_in     = mn_ff;
      hr_in     = hr_ff;
      hp_in     = hp_ff;
      rmin_in   = rmin_ff;
      pmin_in   = pmin_ff;
      ri_in     = ri_ff;
      pi_in     = pi_ff;
      rid_in    = rid_ff;
      pid_in    = pid_ff;
      rten_in   = rten_ff;
      pten_in   = pten_ff;
      sel_in    = sel_ff;
      selten_in = selten_ff;
      wgt_in    = wgt_ff;
      res_in_r  = res_ff_r;
      mem_we    = 1'b0;
      raddr     = qi_ff[QW-1:0];
      waddr     = qi_ff[QW-1:0];
      wdata     = rd_ff;
      add_a     = res_ff[ten_ff];
      add_b     = prod_ff;
      e         = rd_ff;
      rv        = rd_ff.r_tag;
      src       = qi_ff;
      start_i   = '0;

      tv = req_data.tenant;
      for (int k = 0; k < 8; k++) begin
         if (int'(tv) >= TENANTS) tv = tv - 4'(TENANTS);
      end
      nm  = (req_data.now_ms >= rlts_pkg::CLOCK_MOD) ?
            req_data.now_ms - rlts_pkg::CLOCK_MOD : req_data.now_ms;
      ext = {16'b0, nm} << FRAC_BITS;

      r_take = !hr_ff || (e.r_tag < rmin_ff);
      p_take = (e.l_tag <= now_ff) && (!hp_ff || (e.p_tag < pmin_ff));

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               ten_in   = TW'(tv);
               now_in   = (|ext[39:32]) ? 32'hFFFF_FFFF : ext[31:0];
               res_in_r = '0;
               if (!req_data.kind) begin
                  if (count_ff == (QW+1)'(QUEUE_DEPTH)) begin
                     res_in_r.status = rlts_pkg::ST_DROP;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_MUL_R;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  qi_in    = '0;
                  hr_in    = 1'b0;
                  hp_in    = 1'b0;
                  state_in = S_SC_RD;
               end
            end
         end
         S_MUL_R: state_in = S_UPD_R;
         S_UPD_R: begin
            add_a          = res_ff[ten_ff];
            res_in[ten_ff] = add_res;
            state_in       = S_MUL_L;
         end
         S_MUL_L: state_in = S_UPD_L;
         S_UPD_L: begin
            add_a          = lim_ff[ten_ff];
            lim_in[ten_ff] = add_res;
            ti_in          = '0;
            found_in       = 1'b0;
            state_in       = (sh_rd == '0) ? S_SH_MIN : S_UPD_P;
         end
         S_SH_MIN: begin
            // smallest nonzero share tag over all tenants
            if (sh_rd != '0 && (!found_ff || sh_rd < mn_ff)) begin
               mn_in    = sh_rd;
               found_in = 1'b1;
            end
            ti_in = ti_ff + 1'b1;
            if (ti_ff == (TW+1)'(TENANTS - 1)) begin
               ti_in    = '0;
               state_in = found_in ? S_SH_SUB : S_UPD_P;
            end
         end
         S_SH_SUB: begin
            if (sh_rd != '0) sh_in[tidx] = sh_rd - mn_ff;
            ti_in = ti_ff + 1'b1;
            if (ti_ff == (TW+1)'(TENANTS - 1)) state_in = S_UPD_P;
         end
         S_UPD_P: begin
            add_a         = sh_ff[ten_ff];
            add_b         = 32'(33'(1) << FRAC_BITS);
            sh_in[ten_ff] = add_res;
            mem_we        = 1'b1;
            waddr         = count_ff[QW-1:0];
            wdata.r_tag   = res_ff[ten_ff];
            wdata.l_tag   = lim_ff[ten_ff];
            wdata.p_tag   = add_res;
            wdata.id      = req_ff.request_id;
            wdata.tenant  = 4'(ten_ff);
            count_in      = count_ff + 1'b1;
            state_in      = S_DONE;
         end
         S_SC_RD: begin
            raddr    = qi_ff[QW-1:0];
            state_in = S_SC_EV;
         end
         S_SC_EV: begin
            hr_in = 1'b1;
            if (r_take) begin
               rmin_in = e.r_tag;
               ri_in   = qi_ff[QW-1:0];
               rid_in  = e.id;
               rten_in = e.tenant;
            end
            if (p_take) begin
               hp_in   = 1'b1;
               pmin_in = e.p_tag;
               pi_in   = qi_ff[QW-1:0];
               pid_in  = e.id;
               pten_in = e.tenant;
            end
            qi_in = qi_ff + 1'b1;
            if (qi_ff + 1'b1 < count_ff) begin
               state_in = S_SC_RD;
            end else begin
               if (rmin_in <= now_ff) begin
                  res_in_r.status         = rlts_pkg::ST_RES;
                  res_in_r.granted_id     = rid_in;
                  res_in_r.granted_tenant = rten_in;
                  sel_in                  = ri_in;
                  selten_in               = rten_in;
                  wgt_in                  = 1'b0;
                  start_i                 = {1'b0, ri_in};
               end else if (hp_in) begin
                  res_in_r.status         = rlts_pkg::ST_WGT;
                  res_in_r.granted_id     = pid_in;
                  res_in_r.granted_tenant = pten_in;
                  sel_in                  = pi_in;
                  selten_in               = pten_in;
                  wgt_in                  = 1'b1;
                  start_i                 = '0;
               end
               if (res_in_r.status == rlts_pkg::ST_NONE) begin
                  state_in = S_DONE;
               end else if (start_i + 1'b1 < count_ff) begin
                  qi_in    = start_i;
                  state_in = S_CP_RD;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_CP_RD: begin
            // entries past the removed one move down by one
            src      = (qi_ff >= {1'b0, sel_ff}) ? qi_ff + 1'b1 : qi_ff;
            raddr    = src[QW-1:0];
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            wdata = rd_ff;
            if (wgt_ff && rd_ff.tenant == selten_ff) begin
               rv          = (rd_ff.r_tag > 32'(rstep_ff)) ? rd_ff.r_tag - 32'(rstep_ff) : '0;
               wdata.r_tag = rv;
            end
            mem_we = 1'b1;
            waddr  = qi_ff[QW-1:0];
            qi_in  = qi_ff + 1'b1;
            if (qi_ff + (QW+1)'(2) < count_ff) begin
               state_in = S_CP_RD;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (mem_we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rstep_ff <= rlts_pkg::STEP_RESET;
         lstep_ff <= rlts_pkg::STEP_RESET;
         count_ff <= '0;
         for (int t = 0; t < TENANTS; t++) begin
            res_ff[t] <= '0;
            lim_ff[t] <= '0;
            sh_ff[t]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         res_ff   <= res_in;
         lim_ff   <= lim_in;
         sh_ff    <= sh_in;
         if (csr_we) begin
            case (csr_index)
               rlts_pkg::REG_RES_STEP: rstep_ff <= csr_wdata;
               rlts_pkg::REG_LIM_STEP: lstep_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      ten_ff    <= ten_in;
      now_ff    <= now_in;
      prod_ff   <= prod_in;
      qi_ff     <= qi_in;
      ti_ff     <= ti_in;
      found_ff  <= found_in;
      mn_ff     <= mn_in;
      hr_ff     <= hr_in;
      hp_ff     <= hp_in;
      rmin_ff   <= rmin_in;
      pmin_ff   <= pmin_in;
      ri_ff     <= ri_in;
      pi_ff     <= pi_in;
      rid_ff    <= rid_in;
      pid_ff    <= pid_in;
      rten_ff   <= rten_in;
      pten_ff   <= pten_in;
      sel_ff    <= sel_in;
      selten_ff <= selten_in;
      wgt_ff    <= wgt_in;
      res_ff_r  <= res_in_r;
   end

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("response not followed by idle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == rlts_pkg::ST_DROP)
         |-> count_ff == (QW+1)'(QUEUE_DEPTH))
      else $error("drop reported with room in queue");

endmodule
`default_nettype wire

/* tb/reservation_limit_tag_scheduler_checker.sv */
// checker for the reservation/limit tag scheduler: watches the command, response
// and register ports, predicts each response and compares it field by field
// depends on rlts_pkg
`timescale 1ns / 1ps
module reservation_limit_tag_scheduler_checker (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire                    busy,
   input  wire rlts_pkg::req_type req_data,
   input  wire                    rsp_strobe,
   input  wire rlts_pkg::rsp_type rsp_data,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [15:0]             csr_wdata,
   output int                     errors,
   output int                     outstanding,
   output int                     res_grants,
   output int                     wgt_grants,
   output int                     drops
);

   localparam int NTEN  = rlts_pkg::TENANTS_DEF;
   localparam int DEPTH = rlts_pkg::QUEUE_DEPTH_DEF;
   localparam int FRAC  = rlts_pkg::FRAC_BITS_DEF;

   logic [15:0]          res_step, lim_step;
   logic [31:0]          res_tag [NTEN];
   logic [31:0]          lim_tag [NTEN];
   logic [31:0]          share_tag [NTEN];
   rlts_pkg::entry_type  sched_queue [$];
   rlts_pkg::rsp_type    pending_rsps [$];

   function automatic logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] max_tag(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic void clear_model();
      res_step = rlts_pkg::STEP_RESET;
      lim_step = rlts_pkg::STEP_RESET;
      for (int i = 0; i < NTEN; i++) begin
         res_tag[i] = '0;
         lim_tag[i] = '0;
         share_tag[i] = '0;
      end
      sched_queue.delete();
   endfunction

   function automatic rlts_pkg::rsp_type predict_schedule(rlts_pkg::req_type r);
      rlts_pkg::rsp_type   o;
      logic [31:0]         now, mn, rmin, pmin;
      logic [3:0]          ten;
      logic                found, have_r, have_p;
      int                  ri, pi;
      rlts_pkg::entry_type e;
      o = '0;
      now = 32'((64'(r.now_ms) % 64'd10000000) << FRAC);
      if (r.kind == 1'b0) begin
         ten = r.tenant;
         if (sched_queue.size() >= DEPTH) begin
            o.status = rlts_pkg::ST_DROP;
            return o;
         end
         res_tag[ten] = max_tag(sat_add(res_tag[ten], 64'(r.rho) * 64'(res_step)), now);
         lim_tag[ten] = max_tag(sat_add(lim_tag[ten], 64'(r.delta) * 64'(lim_step)), now);
         if (share_tag[ten] == 0) begin
            // renormalize the other tenants against the smallest live share tag
            found = 1'b0;
            mn = '0;
            for (int i = 0; i < NTEN; i++)
               if (share_tag[i] != 0 && (!found || share_tag[i] < mn)) begin
                  mn = share_tag[i];
                  found = 1'b1;
               end
            if (found)
               for (int i = 0; i < NTEN; i++)
                  if (share_tag[i] != 0) share_tag[i] -= mn;
         end
         share_tag[ten] = max_tag(sat_add(share_tag[ten], 64'(1) << FRAC), now);
         e.r_tag = res_tag[ten];
         e.l_tag = lim_tag[ten];
         e.p_tag = share_tag[ten];
         e.id = r.request_id;
         e.tenant = ten;
         sched_queue.push_back(e);
         return o;
      end
      have_r = 1'b0;
      have_p = 1'b0;
      ri = 0;
      pi = 0;
      rmin = '0;
      pmin = '0;
      foreach (sched_queue[i]) begin
         if (!have_r || sched_queue[i].r_tag < rmin) begin
            rmin = sched_queue[i].r_tag;
            ri = i;
            have_r = 1'b1;
         end
         if (sched_queue[i].l_tag <= now && (!have_p || sched_queue[i].p_tag < pmin)) begin
            pmin = sched_queue[i].p_tag;
            pi = i;
            have_p = 1'b1;
         end
      end
      if (have_r && rmin <= now) begin
         o.status = rlts_pkg::ST_RES;
         o.granted_id = sched_queue[ri].id;
         o.granted_tenant = sched_queue[ri].tenant;
         sched_queue.delete(ri);
      end else if (have_p) begin
         ten = sched_queue[pi].tenant;
         o.status = rlts_pkg::ST_WGT;
         o.granted_id = sched_queue[pi].id;
         o.granted_tenant = ten;
         sched_queue.delete(pi);
         foreach (sched_queue[i])
            if (sched_queue[i].tenant == ten)
               sched_queue[i].r_tag = (sched_queue[i].r_tag > res_step) ?
                                      sched_queue[i].r_tag - res_step : '0;
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rlts_pkg::rsp_type want;
      if (reset) begin
         clear_model();
         pending_rsps.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == rlts_pkg::REG_RES_STEP) res_step = csr_wdata;
            else lim_step = csr_wdata;
         end
         if (start && !busy) pending_rsps.push_back(predict_schedule(req_data));
         if (rsp_strobe) begin
            if (pending_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected response %h", $time, rsp_data);
            end else begin
               want = pending_rsps.pop_front();
               case (want.status)
                  rlts_pkg::ST_RES:  res_grants++;
                  rlts_pkg::ST_WGT:  wgt_grants++;
                  rlts_pkg::ST_DROP: drops++;
                  default: ;
               endcase
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.granted_id !== want.granted_id) begin
                  errors++;
                  $display("%0t: granted_id expected %h actual %h",
                           $time, want.granted_id, rsp_data.granted_id);
               end
               if (rsp_data.granted_tenant !== want.granted_tenant) begin
                  errors++;
                  $display("%0t: granted_tenant expected %0d actual %0d",
                           $time, want.granted_tenant, rsp_data.granted_tenant);
               end
            end
         end
      end
      outstanding = pending_rsps.size();
   end
endmodule

/* tb/reservation_limit_tag_scheduler_unit_test.sv */
// top of the scheduler testbench: clock, reset, directed and random commands,
// register writes between phases and the verdict
// depends on rlts_pkg, reservation_limit_tag_scheduler_unit and the checker
`timescale 1ns / 1ps
module reservation_limit_tag_scheduler_unit_test;

   localparam int CYCLE_LIMIT = 1000000;

   logic    clock, reset, start, csr_we, csr_index;
   logic [15:0] csr_wdata;
   rlts_pkg::req_type req_data;
   logic    busy, rsp_strobe;
   rlts_pkg::rsp_type rsp_data;
   int      errors, outstanding, res_grants, wgt_grants, drops;
   int      cycles;
   logic [23:0] clock_ms;

   reservation_limit_tag_scheduler_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   reservation_limit_tag_scheduler_checker scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .outstanding(outstanding), .res_grants(res_grants),
      .wgt_grants(wgt_grants), .drops(drops)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic issue(rlts_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic arrive(logic [3:0] ten, logic [15:0] id, logic [15:0] rho,
                         logic [15:0] dlt, logic [23:0] now);
      issue('{kind: 1'b0, tenant: ten, request_id: id, rho: rho, delta: dlt, now_ms: now});
   endtask

   task automatic grant(logic [23:0] now);
      rlts_pkg::req_type r;
      r = '0;
      r.kind = 1'b1;
      r.tenant = 4'($urandom);
      r.request_id = 16'($urandom);
      r.rho = 16'($urandom);
      r.delta = 16'($urandom);
      r.now_ms = now;
      issue(r);
   endtask

   // quiet point: every transaction answered and the block idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_reg(logic idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic random_item(int arrive_pct);
      logic [15:0] rho, dlt;
      if ($urandom_range(0, 19) == 0) clock_ms = 24'($urandom);
      else clock_ms = clock_ms + 24'($urandom_range(0, 40));
      rho = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      dlt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if ($urandom_range(1, 100) <= arrive_pct)
         arrive(4'($urandom), 16'($urandom), rho, dlt, clock_ms);
      else
         grant(clock_ms);
   endtask

   initial begin
      logic [15:0] res_vals [6];
      logic [15:0] lim_vals [6];
      int          fill_pct [6];
      res_vals = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd300, 16'd256};
      lim_vals = '{16'd256, 16'd65535, 16'd1, 16'd0, 16'd700, 16'd256};
      fill_pct = '{55, 50, 60, 90, 50, 45};
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = rlts_pkg::REG_RES_STEP;
      csr_wdata = '0;
      clock_ms = 24'd100;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, field extremes, renormalization, both grant kinds
      grant(24'd0);
      arrive(4'd0, 16'h0000, 16'd0, 16'd0, 24'd10);
      arrive(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
      arrive(4'd3, 16'h1234, 16'd1, 16'd0, 24'd20);
      arrive(4'd0, 16'h5555, 16'd2, 16'd1, 24'd20);
      grant(24'd5);
      grant(24'd30);
      grant(24'd30);
      arrive(4'd7, 16'hAAAA, 16'd50, 16'd0, 24'd40);
      arrive(4'd7, 16'h0F0F, 16'd50, 16'd0, 24'd40);
      arrive(4'd7, 16'hF0F0, 16'd50, 16'd0, 24'd40);
      grant(24'd41);
      grant(24'd41);
      grant(24'd9999999);
      grant(24'd10000000);
      grant(24'hFFFFFF);
      grant(24'd0);

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_reg(rlts_pkg::REG_RES_STEP, res_vals[ph]);
         write_reg(rlts_pkg::REG_LIM_STEP, lim_vals[ph]);
         csr_we <= 1'b0;
         for (int n = 0; n < 100; n++) random_item(fill_pct[ph]);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d reservation grants, %0d weight grants, %0d drops",
               res_grants, wgt_grants, drops);
      $display("over six step settings including both extremes, in %0d cycles", cycles);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
